[sv/key_matrix_hid_report_builder_assert.svh]
// ----------------------------------------------------------------------------
// Key matrix HID report builder assertion macros
// Assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_HID_REPORT_BUILDER_ASSERT_SVH
`define KEY_MATRIX_HID_REPORT_BUILDER_ASSERT_SVH

`ifndef SYNTH
// Checked while the block is out of reset.
`define KMHID_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge, reset included.
`define KMHID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMHID_ASSERT(label, clk, rstn, prop, msg)
`define KMHID_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/kmhid_pkg.sv]
// ----------------------------------------------------------------------------
// Key matrix HID report builder package
// Shared widths, the keycode table and the controller/datapath interface.
// ----------------------------------------------------------------------------
package kmhid_pkg;

    // Scan bitmap and position widths.
    localparam int IN_BITS  = 20;
    localparam int POS_W    = 5;
    localparam int COORD_W  = 5;
    localparam int KEY_W    = 8;

    // Report layout.
    localparam int NUM_SLOTS  = 6;
    localparam int SLOT_W     = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;

    // Modifier keycode range.
    localparam logic [KEY_W-1:0] MOD_LOW  = 8'h80;
    localparam logic [KEY_W-1:0] MOD_HIGH = 8'h87;

    // Keycode table, row-major.
    localparam int TAB_ROWS = 5;
    localparam int TAB_COLS = 4;
    localparam logic [KEY_W-1:0] KEY_TABLE [TAB_ROWS][TAB_COLS] = '{
        '{8'h53, 8'h60, 8'h5E, 8'h62},
        '{8'h54, 8'h61, 8'h59, 8'h63},
        '{8'h55, 8'h57, 8'h5A, 8'h00},
        '{8'h56, 8'h5C, 8'h5B, 8'h00},
        '{8'h5F, 8'h5D, 8'h28, 8'h00}
    };

    // Keycode of a matrix coordinate; zero outside the table.
    function automatic logic [KEY_W-1:0] keycode_of(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
        logic [KEY_W-1:0] code;
        code = '0;
        if (row < COORD_W'(TAB_ROWS) && col < COORD_W'(TAB_COLS)) begin
            code = KEY_TABLE[row[2:0]][col[1:0]];
        end
        return code;
    endfunction

    function automatic logic is_modifier(input logic [KEY_W-1:0] code);
        return (code >= MOD_LOW) && (code <= MOD_HIGH);
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic prune_init;
        logic prune_step;
        logic append_init;
        logic append_step;
        logic fill_init;
        logic fill_step;
        logic out_load;
    } kmhid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic prune_done;
        logic append_last;
        logic fill_done;
        logic out_free;
    } kmhid_status_t;

endpackage

[sv/kmhid_ctrl.sv]
// ----------------------------------------------------------------------------
// Key matrix HID report builder controller
// Sequences scan, prune, append, fill and report hand-off for one request.
// ----------------------------------------------------------------------------
`include "key_matrix_hid_report_builder_assert.svh"

module kmhid_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  kmhid_pkg::kmhid_status_t status,
    output kmhid_pkg::kmhid_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE_SETUP,
        ST_PRUNE,
        ST_APPEND,
        ST_FILL_SETUP,
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new request is taken only between passes.
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and the command for this cycle.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_PRUNE_SETUP;
                end
            end
            ST_PRUNE_SETUP: begin
                cmd.prune_init = 1'b1;
                state_next     = ST_PRUNE;
            end
            ST_PRUNE: begin
                if (status.prune_done) begin
                    cmd.append_init = 1'b1;
                    state_next      = ST_APPEND;
                end else begin
                    cmd.prune_step = 1'b1;
                end
            end
            ST_APPEND: begin
                cmd.append_step = 1'b1;
                if (status.append_last) begin
                    state_next = ST_FILL_SETUP;
                end
            end
            ST_FILL_SETUP: begin
                cmd.fill_init = 1'b1;
                state_next    = ST_FILL;
            end
            ST_FILL: begin
                if (status.fill_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The datapath must never see two commands at once.
    `KMHID_ASSERT(a_cmd_single, aclk, aresetn, $onehot0(cmd), "more than one command issued")
    // Reset always returns the sequencer to idle.
    `KMHID_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE), "not idle after reset")
    // A finished report waits while the output register is still occupied.
    `KMHID_ASSERT(a_emit_wait, aclk, aresetn, (state_reg == ST_EMIT && !status.out_free) |=> (state_reg == ST_EMIT), "report left before the output was free")

endmodule

[sv/kmhid_datapath.sv]
// ----------------------------------------------------------------------------
// Key matrix HID report builder datapath
// Held-key list, scan bitmaps, modifier tracking and the report register.
// ----------------------------------------------------------------------------
`include "key_matrix_hid_report_builder_assert.svh"

module kmhid_datapath #(
    parameter int ROWS        = 5,
    parameter int COLS        = 4,
    parameter int MAX_HELD    = 10,
    parameter int REPORT_KEYS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kmhid_pkg::kmhid_cmd_t              cmd,
    output kmhid_pkg::kmhid_status_t           status,
    input  logic [kmhid_pkg::IN_BITS-1:0]      key_matrix,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kmhid_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int POS_W   = kmhid_pkg::POS_W;
    localparam int COORD_W = kmhid_pkg::COORD_W;
    localparam int KEY_W   = kmhid_pkg::KEY_W;
    localparam int SLOT_W  = kmhid_pkg::SLOT_W;
    localparam int NPOS    = (ROWS * COLS < kmhid_pkg::IN_BITS) ? ROWS * COLS
                                                                 : kmhid_pkg::IN_BITS;
    localparam int CNT_W   = $clog2(MAX_HELD + 1);
    localparam int IDX_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(NPOS - 1);
    localparam logic [COORD_W-1:0] LAST_COL   = COORD_W'(COLS - 1);
    localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_HELD);
    localparam logic [SLOT_W-1:0]  SLOT_LIMIT = SLOT_W'(REPORT_KEYS);

    // Control and counter registers.
    logic [kmhid_pkg::IN_BITS-1:0] matrix_reg;
    logic [kmhid_pkg::IN_BITS-1:0] scan_map_reg;
    logic [kmhid_pkg::IN_BITS-1:0] held_map_reg;
    logic [CNT_W-1:0]              scan_cnt_reg;
    logic [CNT_W-1:0]              held_cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              keep_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [COORD_W-1:0]            row_reg;
    logic [COORD_W-1:0]            col_reg;
    logic [1:0]                    mod_cnt_reg;
    logic [KEY_W-1:0]              mod_code_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          m_tvalid_reg;

    // Payload storage.
    logic [POS_W-1:0]              held_pos_reg [MAX_HELD];
    logic [KEY_W-1:0]              held_key_reg [MAX_HELD];
    logic [KEY_W-1:0]              slot_key_reg [kmhid_pkg::NUM_SLOTS];
    logic [kmhid_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [KEY_W-1:0] cur_key;
    logic [POS_W-1:0] rd_pos;
    logic [KEY_W-1:0] rd_key;
    logic             keep_hit;
    logic             append_hit;
    logic             mod_one;
    logic             fill_skip;
    logic             mod_event;
    logic [KEY_W-1:0] mod_key;

    // Keycode of the position under the scan cursor and the list entry under idx.
    assign cur_key    = kmhid_pkg::keycode_of(row_reg, col_reg);
    assign rd_pos     = held_pos_reg[idx_reg[IDX_W-1:0]];
    assign rd_key     = held_key_reg[idx_reg[IDX_W-1:0]];
    assign keep_hit   = scan_map_reg[rd_pos];
    assign append_hit = scan_map_reg[pos_reg] && !held_map_reg[pos_reg]
                        && (held_cnt_reg < MAX_CNT);
    assign mod_one    = (mod_cnt_reg == 2'd1);
    assign fill_skip  = mod_one && (rd_key == mod_code_reg);

    // A modifier is counted whenever a modifier entry lands in the final list.
    always_comb begin
        mod_event = 1'b0;
        mod_key   = cur_key;
        if (cmd.prune_step && keep_hit) begin
            mod_event = kmhid_pkg::is_modifier(rd_key);
            mod_key   = rd_key;
        end else if (cmd.append_step && append_hit) begin
            mod_event = kmhid_pkg::is_modifier(cur_key);
        end
    end

    // Status back to the controller.
    always_comb begin
        status.scan_last   = (pos_reg == LAST_POS);
        status.prune_done  = (idx_reg == held_cnt_reg);
        status.append_last = (pos_reg == LAST_POS);
        status.fill_done   = (idx_reg == held_cnt_reg) || (slot_reg == SLOT_LIMIT);
        status.out_free    = !m_tvalid_reg || m_tready;
    end

    // Control state: counters, bitmaps and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_map_reg <= '0;
            held_cnt_reg <= '0;
            scan_map_reg <= '0;
            scan_cnt_reg <= '0;
            idx_reg      <= '0;
            keep_reg     <= '0;
            pos_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            mod_cnt_reg  <= '0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Start of a request: clear the scan bitmap and cursor.
            if (cmd.load) begin
                scan_map_reg <= '0;
                scan_cnt_reg <= '0;
                pos_reg      <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
            end

            // Keep the first MAX_HELD pressed positions in scan order.
            if (cmd.scan_step) begin
                if (matrix_reg[pos_reg] && (scan_cnt_reg < MAX_CNT)) begin
                    scan_map_reg[pos_reg] <= 1'b1;
                    scan_cnt_reg          <= scan_cnt_reg + 1'b1;
                end
            end

            // Released keys leave the held set before compaction.
            if (cmd.prune_init) begin
                held_map_reg <= held_map_reg & scan_map_reg;
                idx_reg      <= '0;
                keep_reg     <= '0;
                mod_cnt_reg  <= '0;
            end

            if (cmd.prune_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (keep_hit) begin
                    keep_reg <= keep_reg + 1'b1;
                end
            end

            // The compacted length becomes the list length, and the cursor rewinds.
            if (cmd.append_init) begin
                held_cnt_reg <= keep_reg;
                pos_reg      <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
            end

            if (cmd.append_step && append_hit) begin
                held_map_reg[pos_reg] <= 1'b1;
                held_cnt_reg          <= held_cnt_reg + 1'b1;
            end

            // Scan cursor walks positions in row-major order.
            if (cmd.scan_step || cmd.append_step) begin
                pos_reg <= pos_reg + 1'b1;
                if (col_reg == LAST_COL) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            // Modifier count saturates at two.
            if (mod_event && (mod_cnt_reg != 2'd2)) begin
                mod_cnt_reg <= mod_cnt_reg + 2'd1;
            end

            if (cmd.fill_init) begin
                idx_reg  <= '0;
                slot_reg <= '0;
            end

            if (cmd.fill_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (!fill_skip) begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end

            // Output valid: set on load, cleared when the report is taken.
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: held list, report slots and output data.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            matrix_reg <= key_matrix;
        end

        if (cmd.prune_step && keep_hit) begin
            held_pos_reg[keep_reg[IDX_W-1:0]] <= rd_pos;
            held_key_reg[keep_reg[IDX_W-1:0]] <= rd_key;
        end

        if (cmd.append_step && append_hit) begin
            held_pos_reg[held_cnt_reg[IDX_W-1:0]] <= pos_reg;
            held_key_reg[held_cnt_reg[IDX_W-1:0]] <= cur_key;
        end

        if (mod_event) begin
            mod_code_reg <= mod_key;
        end

        if (cmd.fill_init) begin
            for (int i = 0; i < kmhid_pkg::NUM_SLOTS; i++) begin
                slot_key_reg[i] <= '0;
            end
        end

        if (cmd.fill_step && !fill_skip) begin
            slot_key_reg[slot_reg] <= rd_key;
        end

        // Report layout from the lowest bit: modifier, reserved, six key slots.
        if (cmd.out_load) begin
            m_tdata_reg <= {7'b0,
                            slot_key_reg[5], slot_key_reg[4], slot_key_reg[3],
                            slot_key_reg[2], slot_key_reg[1], slot_key_reg[0],
                            1'b0,
                            (mod_one ? mod_code_reg : {KEY_W{1'b0}})};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Between requests the bitmap and the list length agree.
    `KMHID_ASSERT(a_map_matches_count, aclk, aresetn, cmd.load |-> ($countones(held_map_reg) == held_cnt_reg), "held bitmap and count disagree")
    // A report never overwrites one that is still waiting.
    `KMHID_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_tvalid_reg || m_tready), "report register overwritten")
    // A fill step stays inside the list and the slot range.
    `KMHID_ASSERT(a_fill_bounds, aclk, aresetn, cmd.fill_step |-> ((slot_reg < SLOT_LIMIT) && (idx_reg < held_cnt_reg)), "fill step out of range")

endmodule

[sv/key_matrix_hid_report_builder.sv]
// ----------------------------------------------------------------------------
// Key matrix HID report builder
// Turns each key matrix scan into an 8-byte keyboard report.
//
//   Channel   Direction  Payload
//   s_        in         key_matrix (one scan bitmap)
//   m_        out        modifier, reserved, six key slots
//
// From acceptance to the report entering the output register, one scan runs a
// walk over the matrix positions, a prune over the keys held before the scan,
// a second walk over the matrix positions to append new keys, and a fill over
// the list entries; the two walks over the matrix positions dominate. The next
// scan is accepted from the cycle after the report has been loaded, even while
// it still waits to be taken; a stalled report holds the controller before
// loading. Reset is synchronous and empties the held list.
// ----------------------------------------------------------------------------
module key_matrix_hid_report_builder #(
    parameter int ROWS        = 5,
    parameter int COLS        = 4,
    parameter int MAX_HELD    = 10,
    parameter int REPORT_KEYS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Scan input.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kmhid_pkg::S_TDATA_W-1:0]    s_tdata,   // [19:0] key_matrix
    // Report output.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kmhid_pkg::M_TDATA_W-1:0]    m_tdata    // [7:0] modifier_byte,
                                                          // [8] reserved_bit,
                                                          // [16:9] key_slot_one,
                                                          // [24:17] key_slot_two,
                                                          // [32:25] key_slot_three,
                                                          // [40:33] key_slot_four,
                                                          // [48:41] key_slot_five,
                                                          // [56:49] key_slot_six
);

    kmhid_pkg::kmhid_cmd_t    cmd;
    kmhid_pkg::kmhid_status_t status;

    // Sequencer.
    kmhid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Held list and report datapath.
    kmhid_datapath #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .MAX_HELD    (MAX_HELD),
        .REPORT_KEYS (REPORT_KEYS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .key_matrix (s_tdata[kmhid_pkg::IN_BITS-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
